[hdl/mctb_pkg.sv]
// Shared types and constants for the multi-channel timer bank.
// Used by the controller, the datapath and the top level; no dependencies.
`default_nettype none

package mctb_pkg;

   // Default sizing of the bank
   localparam int DEF_CHANNELS    = 32;
   localparam int DEF_COUNT_WIDTH = 32;

   // Fixed field widths of the request and response beats
   localparam int OP_W       = 3;
   localparam int CHAN_W     = 5;
   localparam int INTERVAL_W = 32;
   localparam int KIND_W     = 2;

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK  = 3'd0;
   localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
   localparam logic [OP_W-1:0] OP_LINK  = 3'd2;
   localparam logic [OP_W-1:0] OP_START = 3'd3;
   localparam logic [OP_W-1:0] OP_STOP  = 3'd4;
   localparam logic [OP_W-1:0] OP_FREE  = 3'd5;

   // Response kinds
   localparam logic [KIND_W-1:0] KIND_FIRED     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ALLOCATED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NO_FREE   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_DONE      = 2'd3;

   // Request beat
   typedef struct packed {
      logic [OP_W-1:0]       operation;
      logic [CHAN_W-1:0]     channel;
      logic [INTERVAL_W-1:0] interval;
      logic                  one_shot;
   } req_type;

   // Response beat
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [CHAN_W-1:0] channel_out;
      logic              last;
   } rsp_type;

   // Controller to datapath commands
   typedef struct packed {
      logic load_req;      // capture the accepted request beat
      logic scan_clear;    // reset scan index and pending fire
      logic scan_step;     // advance scan index
      logic scan_read;     // read count and reload of the scanned channel
      logic scan_commit;   // write back the decremented count or the reload, record a fire
      logic scan_finish;   // emit the closing beat of a tick
      logic fifo_read;     // read the free list head
      logic alloc_commit;  // take the head channel and emit it
      logic start_read;    // read the reload value of the target channel
      logic start_commit;  // load count from reload and set running
      logic simple_apply;  // apply link, stop or free to the flags and the free list
      logic reply;         // emit a single done or no-free beat
   } cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic [OP_W-1:0] op;
      logic            ch_ok;
      logic            fifo_empty;
      logic            idx_active;
      logic            idx_last;
      logic            fire;
      logic            pend_valid;
      logic            slot_free;
   } status_type;

endpackage

`default_nettype wire

[hdl/multi_channel_timer_bank_top.sv]
// Top level of the multi-channel timer bank: controller plus datapath.
// Depends on mctb_pkg, mctb_ctrl, mctb_dpath (and mctb_ram below it).
//
//   channel  dir  handshake              beat
//   req_     in   req_valid / req_ready  mctb_pkg::req_type
//   rsp_     out  rsp_valid / rsp_ready  mctb_pkg::rsp_type
//
// Link, stop and free pass through dispatch and reply; allocate through dispatch
// and allocate (reply if no channel is free); start reads the reload first. A tick
// visits every channel in turn and reads and updates each linked running one.
// The scan speed is set by the registered read of the count memory.
// Reset is synchronous; no memory clearing pass is needed after it.
// A full response register stalls the sequence; a new request is taken
// while the last response of the previous one still waits.
`default_nettype none

module multi_channel_timer_bank_top #(
   parameter int CHANNELS    = mctb_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = mctb_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mctb_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mctb_pkg::rsp_type      rsp_data
);

   mctb_pkg::cmd_type    cmd;
   mctb_pkg::status_type status;

   mctb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mctb_dpath #(
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

[hdl/mctb_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mctb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write the addressed word
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Register the read word; hold it while no read is issued
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

[hdl/mctb_ctrl.sv]
// Controller state machine of the timer bank: sequences each operation.
// Depends on mctb_pkg for the command and status structs and op codes.
`default_nettype none

module mctb_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire mctb_pkg::status_type status,
   output mctb_pkg::cmd_type        cmd
);

   typedef enum logic [7:0] {
      S_IDLE        = 8'b0000_0001,
      S_DISPATCH    = 8'b0000_0010,
      S_REPLY       = 8'b0000_0100,
      S_ALLOC       = 8'b0000_1000,
      S_START       = 8'b0001_0000,
      S_SCAN_ISSUE  = 8'b0010_0000,
      S_SCAN_UPDATE = 8'b0100_0000,
      S_SCAN_END    = 8'b1000_0000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            priority if (status.op == mctb_pkg::OP_TICK) begin
               cmd.scan_clear = 1'b1;
               state_in       = S_SCAN_ISSUE;
            end else if (status.op == mctb_pkg::OP_ALLOC) begin
               if (status.fifo_empty) begin
                  state_in = S_REPLY;
               end else begin
                  cmd.fifo_read = 1'b1;
                  state_in      = S_ALLOC;
               end
            end else if (status.op == mctb_pkg::OP_START && status.ch_ok) begin
               cmd.start_read = 1'b1;
               state_in       = S_START;
            end else begin
               cmd.simple_apply = 1'b1;
               state_in         = S_REPLY;
            end
         end
         S_START: begin
            cmd.start_commit = 1'b1;
            state_in         = S_REPLY;
         end
         S_REPLY: begin
            if (status.slot_free) begin
               cmd.reply = 1'b1;
               state_in  = S_IDLE;
            end
         end
         S_ALLOC: begin
            if (status.slot_free) begin
               cmd.alloc_commit = 1'b1;
               state_in         = S_IDLE;
            end
         end
         S_SCAN_ISSUE: begin
            priority if (status.idx_active) begin
               cmd.scan_read = 1'b1;
               state_in      = S_SCAN_UPDATE;
            end else if (status.idx_last) begin
               state_in = S_SCAN_END;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         S_SCAN_UPDATE: begin
            // hold while an earlier fire must go out and the output is full
            if (!(status.fire && status.pend_valid) || status.slot_free) begin
               cmd.scan_commit = 1'b1;
               if (status.idx_last) begin
                  state_in = S_SCAN_END;
               end else begin
                  cmd.scan_step = 1'b1;
                  state_in      = S_SCAN_ISSUE;
               end
            end
         end
         S_SCAN_END: begin
            if (status.slot_free) begin
               cmd.scan_finish = 1'b1;
               state_in        = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Advance state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);

endmodule

`default_nettype wire

[hdl/mctb_dpath.sv]
// Datapath of the timer bank: count and reload memories, channel flags,
// free list, scan index, pending fire and response register.
// Depends on mctb_pkg and mctb_ram.
`default_nettype none

module mctb_dpath #(
   parameter int CHANNELS    = mctb_pkg::DEF_CHANNELS,
   parameter int COUNT_WIDTH = mctb_pkg::DEF_COUNT_WIDTH
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mctb_pkg::req_type    req_data,
   input  wire mctb_pkg::cmd_type    cmd,
   output mctb_pkg::status_type      status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output mctb_pkg::rsp_type         rsp_data
);

   localparam int CH_W  = $clog2(CHANNELS);
   localparam int CNT_W = $clog2(CHANNELS + 1);

   // Request and derived fields
   mctb_pkg::req_type       req_ff;
   logic [CH_W-1:0]         ch_idx;
   logic                    ch_ok;
   logic [COUNT_WIDTH-1:0]  interval_val;

   // Flags
   logic [CHANNELS-1:0] running_ff, running_in;
   logic [CHANNELS-1:0] single_ff, single_in;
   logic [CHANNELS-1:0] linked_ff, linked_in;

   // Free list
   logic [CHANNELS-1:0] fifo_vld_ff, fifo_vld_in;
   logic [CH_W-1:0]     head_ff, head_in;
   logic [CH_W-1:0]     tail_ff, tail_in;
   logic [CNT_W-1:0]    fcnt_ff, fcnt_in;
   logic                fifo_wr;
   logic [CH_W-1:0]     fifo_rd;
   logic [CH_W-1:0]     alloc_ch;

   // Scan
   logic [CH_W-1:0]     idx_ff, idx_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [CH_W-1:0]     pend_ch_ff, pend_ch_in;
   logic                idx_last;
   logic                fire;

   // Memories
   logic                   cnt_wr;
   logic [CH_W-1:0]        cnt_waddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata;
   logic [COUNT_WIDTH-1:0] cnt_rd;
   logic [COUNT_WIDTH-1:0] cnt_dec;
   logic                   rld_rd_en;
   logic [CH_W-1:0]        rld_raddr;
   logic [COUNT_WIDTH-1:0] rld_rd;

   // Response
   logic              rsp_valid_ff, rsp_valid_in;
   mctb_pkg::rsp_type rsp_data_ff, rsp_data_in;
   logic              slot_free;
   logic              emit;
   logic              emit_pend;

   // Capture request beat
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
   end

   assign ch_idx       = CH_W'(req_ff.channel);
   assign ch_ok        = (32'(req_ff.channel) < CHANNELS);
   assign interval_val = COUNT_WIDTH'(req_ff.interval);

   // Scan decode
   assign idx_last  = (idx_ff == CH_W'(CHANNELS - 1));
   assign cnt_dec   = cnt_rd - COUNT_WIDTH'(1);
   assign fire      = (cnt_dec == '0);
   assign emit_pend = cmd.scan_commit && fire && pend_valid_ff;

   // Free list head: an entry never written still holds its own index
   assign alloc_ch = fifo_vld_ff[head_ff] ? fifo_rd : head_ff;

   assign fifo_wr = cmd.simple_apply && ch_ok && (req_ff.operation == mctb_pkg::OP_FREE)
                    && linked_ff[ch_idx] && (fcnt_ff != CNT_W'(CHANNELS));

   // Count memory write port
   always_comb begin
      cnt_wr    = 1'b0;
      cnt_waddr = idx_ff;
      cnt_wdata = fire ? rld_rd : cnt_dec;
      priority if (cmd.alloc_commit) begin
         cnt_wr    = 1'b1;
         cnt_waddr = alloc_ch;
         cnt_wdata = interval_val;
      end else if (cmd.start_commit) begin
         cnt_wr    = 1'b1;
         cnt_waddr = ch_idx;
         cnt_wdata = rld_rd;
      end else if (cmd.scan_commit) begin
         cnt_wr = 1'b1;
      end else begin
         cnt_wr = 1'b0;
      end
   end

   assign rld_rd_en = cmd.scan_read || cmd.start_read;
   assign rld_raddr = cmd.start_read ? ch_idx : idx_ff;

   mctb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (CHANNELS)
   ) u_count_ram (
      .clock   (clock),
      .wr_en   (cnt_wr),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_en   (cmd.scan_read),
      .rd_addr (idx_ff),
      .rd_data (cnt_rd)
   );

   mctb_ram #(
      .WIDTH (COUNT_WIDTH),
      .DEPTH (CHANNELS)
   ) u_reload_ram (
      .clock   (clock),
      .wr_en   (cmd.alloc_commit),
      .wr_addr (alloc_ch),
      .wr_data (interval_val),
      .rd_en   (rld_rd_en),
      .rd_addr (rld_raddr),
      .rd_data (rld_rd)
   );

   mctb_ram #(
      .WIDTH (CH_W),
      .DEPTH (CHANNELS)
   ) u_free_ram (
      .clock   (clock),
      .wr_en   (fifo_wr),
      .wr_addr (tail_ff),
      .wr_data (ch_idx),
      .rd_en   (cmd.fifo_read),
      .rd_addr (head_ff),
      .rd_data (fifo_rd)
   );

   // Channel flags
   always_comb begin
      running_in = running_ff;
      single_in  = single_ff;
      linked_in  = linked_ff;
      if (cmd.alloc_commit) begin
         running_in[alloc_ch] = 1'b0;
         single_in[alloc_ch]  = req_ff.one_shot;
         linked_in[alloc_ch]  = 1'b0;
      end
      if (cmd.start_commit) begin
         running_in[ch_idx] = 1'b1;
      end
      if (cmd.simple_apply && ch_ok) begin
         unique case (req_ff.operation)
            mctb_pkg::OP_LINK: linked_in[ch_idx] = 1'b1;
            mctb_pkg::OP_STOP: running_in[ch_idx] = 1'b0;
            mctb_pkg::OP_FREE: begin
               running_in[ch_idx] = 1'b0;
               linked_in[ch_idx]  = 1'b0;
            end
            default: ;
         endcase
      end
      // drop a one-shot channel after it fires
      if (cmd.scan_commit && fire && single_ff[idx_ff]) begin
         running_in[idx_ff] = 1'b0;
      end
   end

   // Free list pointers
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fcnt_in     = fcnt_ff;
      fifo_vld_in = fifo_vld_ff;
      if (cmd.alloc_commit) begin
         head_in = (head_ff == CH_W'(CHANNELS - 1)) ? '0 : head_ff + CH_W'(1);
         fcnt_in = fcnt_ff - CNT_W'(1);
      end
      if (fifo_wr) begin
         fifo_vld_in[tail_ff] = 1'b1;
         tail_in = (tail_ff == CH_W'(CHANNELS - 1)) ? '0 : tail_ff + CH_W'(1);
         fcnt_in = fcnt_ff + CNT_W'(1);
      end
   end

   // Scan index and pending fire
   always_comb begin
      idx_in        = idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_ch_in    = pend_ch_ff;
      if (cmd.scan_clear) begin
         idx_in        = '0;
         pend_valid_in = 1'b0;
      end
      if (cmd.scan_step) begin
         idx_in = idx_ff + CH_W'(1);
      end
      if (cmd.scan_commit && fire) begin
         pend_valid_in = 1'b1;
         pend_ch_in    = idx_ff;
      end
   end

   // Response register
   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign emit      = cmd.reply || cmd.alloc_commit || cmd.scan_finish || emit_pend;

   always_comb begin
      rsp_data_in = rsp_data_ff;
      priority if (cmd.reply) begin
         rsp_data_in.kind = (req_ff.operation == mctb_pkg::OP_ALLOC) ?
                            mctb_pkg::KIND_NO_FREE : mctb_pkg::KIND_DONE;
         rsp_data_in.channel_out = '0;
         rsp_data_in.last        = 1'b1;
      end else if (cmd.alloc_commit) begin
         rsp_data_in.kind        = mctb_pkg::KIND_ALLOCATED;
         rsp_data_in.channel_out = mctb_pkg::CHAN_W'(alloc_ch);
         rsp_data_in.last        = 1'b1;
      end else if (emit_pend) begin
         rsp_data_in.kind        = mctb_pkg::KIND_FIRED;
         rsp_data_in.channel_out = mctb_pkg::CHAN_W'(pend_ch_ff);
         rsp_data_in.last        = 1'b0;
      end else if (cmd.scan_finish) begin
         rsp_data_in.kind        = pend_valid_ff ? mctb_pkg::KIND_FIRED : mctb_pkg::KIND_DONE;
         rsp_data_in.channel_out = pend_valid_ff ? mctb_pkg::CHAN_W'(pend_ch_ff) : '0;
         rsp_data_in.last        = 1'b1;
      end else begin
         rsp_data_in = rsp_data_ff;
      end
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ch_ff  <= pend_ch_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         single_ff     <= '0;
         linked_ff     <= '0;
         fifo_vld_ff   <= '0;
         head_ff       <= '0;
         tail_ff       <= '0;
         fcnt_ff       <= CNT_W'(CHANNELS);
         idx_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         running_ff    <= running_in;
         single_ff     <= single_in;
         linked_ff     <= linked_in;
         fifo_vld_ff   <= fifo_vld_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         fcnt_ff       <= fcnt_in;
         idx_ff        <= idx_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Status to the controller
   always_comb begin
      status            = '0;
      status.op         = req_ff.operation;
      status.ch_ok      = ch_ok;
      status.fifo_empty = (fcnt_ff == '0);
      status.idx_active = linked_ff[idx_ff] && running_ff[idx_ff];
      status.idx_last   = idx_last;
      status.fire       = fire;
      status.pend_valid = pend_valid_ff;
      status.slot_free  = slot_free;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTH
   a_emit_slot: assert property (@(posedge clock) disable iff (reset)
      emit |-> slot_free)
      else $error("beat emitted while the response register is occupied");

   a_fcnt_range: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff <= CNT_W'(CHANNELS))
      else $error("free list count above channel count");

   a_alloc_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.alloc_commit |-> (fcnt_ff != '0))
      else $error("allocation from an empty free list");

   a_scan_active: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_read |=> (linked_ff[$past(idx_ff)] && running_ff[$past(idx_ff)]))
      else $error("scanned channel lost its active state before update");
`endif

endmodule

`default_nettype wire
